// ===== rtl/zdzm_pkg.sv =====
// Shared types and constants of the zone manager: request and result payloads,
// command codes and zone condition codes. Depends on nothing.
package zdzm_pkg;

  // Command codes carried in the mode field
  localparam logic [2:0] MODE_WRITE     = 3'd0;
  localparam logic [2:0] MODE_APPEND    = 3'd1;
  localparam logic [2:0] MODE_OPEN      = 3'd2;
  localparam logic [2:0] MODE_CLOSE     = 3'd3;
  localparam logic [2:0] MODE_FINISH    = 3'd4;
  localparam logic [2:0] MODE_RESET     = 3'd5;
  localparam logic [2:0] MODE_RESET_ALL = 3'd6;
  localparam logic [2:0] MODE_REPORT    = 3'd7;

  // Zone conditions
  localparam logic [2:0] COND_EMPTY    = 3'd0;
  localparam logic [2:0] COND_IMP_OPEN = 3'd1;
  localparam logic [2:0] COND_EXP_OPEN = 3'd2;
  localparam logic [2:0] COND_CLOSED   = 3'd3;
  localparam logic [2:0] COND_FULL     = 3'd4;

  // Largest number of zones one report returns
  localparam int unsigned MAX_REPORT = 32;

  typedef struct packed {
    logic [2:0]  mode;
    logic [20:0] sector_address;
    logic [16:0] length_sectors;
    logic [5:0]  zone_count;
  } cmd_t;

  typedef struct packed {
    logic        status;
    logic [20:0] written_at;
    logic [20:0] zone_start;
    logic [21:0] zone_write_pointer;
    logic [2:0]  zone_condition;
    logic [5:0]  reported_count;
    logic        last;
  } res_t;

endpackage

// ===== rtl/zdzm_stream_if.sv =====
// Valid/ready channel carrying one payload per transfer.
// Depends on nothing; the payload type is set by the instance.
interface zdzm_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/zdzm_out_reg.sv =====
// Output register of the zone manager: holds one result until the sink takes it.
// Depends on zdzm_pkg and zdzm_stream_if.
module zdzm_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  input  zdzm_pkg::res_t   push_data,
  output logic             push_ready,
  zdzm_stream_if.source    res
);
  import zdzm_pkg::*;

  logic full;
  res_t data;

  assign push_ready = !full || res.ready;
  assign res.valid  = full;
  assign res.data   = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (push_ready) begin
      full <= push_valid;
    end
    if (push_ready && push_valid) begin
      data <= push_data;
    end
  end

endmodule

// ===== rtl/zdzm_zone_update.sv =====
// Zone command logic: checks a command against the zone entry read from the
// table, forms the written-back entry and the result. Depends on zdzm_pkg.
module zdzm_zone_update #(
  parameter int ZONE_SECTORS_LOG2 = 16,
  parameter int ZW                = 5,
  parameter int OW                = 17
) (
  input  zdzm_pkg::cmd_t  cmd,
  input  logic            oor,
  input  logic [2:0]      cond,
  input  logic [OW-1:0]   off,
  input  logic [ZW-1:0]   rpt_zone,
  input  logic [5:0]      rpt_n,
  input  logic [5:0]      rpt_i,
  output logic            wr_en,
  output logic [2:0]      wr_cond,
  output logic [OW-1:0]   wr_off,
  output zdzm_pkg::res_t  res
);
  import zdzm_pkg::*;

  localparam int SUMW = ((OW > 17) ? OW : 17) + 1;
  localparam int QW   = ((ZW + ZONE_SECTORS_LOG2) > 22) ? (ZW + ZONE_SECTORS_LOG2) : 22;
  localparam logic [OW-1:0] ZLEN = {1'b1, {ZONE_SECTORS_LOG2{1'b0}}};

  logic [31:0]   addr32;
  logic [OW-1:0] addr_low;
  logic [21:0]   zstart;
  logic [21:0]   wp;
  logic [SUMW-1:0] sum;
  logic [OW-1:0] sum_off;
  logic          fits;
  logic [QW-1:0] qs;
  logic [QW-1:0] qwp;

  assign addr32   = 32'(cmd.sector_address);
  assign addr_low = OW'(addr32 & ((32'd1 << ZONE_SECTORS_LOG2) - 32'd1));
  assign zstart   = 22'((addr32 >> ZONE_SECTORS_LOG2) << ZONE_SECTORS_LOG2);
  assign wp       = zstart + 22'(off);
  assign sum      = SUMW'(off) + SUMW'(cmd.length_sectors);
  assign sum_off  = OW'(sum);
  assign fits     = sum <= SUMW'(ZLEN);
  assign qs       = QW'(rpt_zone) << ZONE_SECTORS_LOG2;
  assign qwp      = qs + QW'(off);

  always_comb begin
    wr_en    = 1'b0;
    wr_cond  = cond;
    wr_off   = off;
    res      = '0;
    res.last = 1'b1;
    if (oor && cmd.mode != MODE_RESET_ALL) begin
      res.status = 1'b1;
    end else begin
      unique case (cmd.mode) inside
        MODE_WRITE, MODE_APPEND: begin
          if ((cmd.mode == MODE_WRITE && addr_low != off) || !fits || cond >= COND_FULL) begin
            res.status = 1'b1;
          end else begin
            wr_en  = 1'b1;
            wr_off = sum_off;
            if (cond == COND_EMPTY || cond == COND_CLOSED) begin
              wr_cond = COND_IMP_OPEN;
            end
            if (sum_off == ZLEN) begin
              wr_cond = COND_FULL;
            end
            res.written_at = wp[20:0];
          end
        end
        MODE_OPEN: begin
          if (cond >= COND_FULL) begin
            res.status = 1'b1;
          end else begin
            wr_en   = 1'b1;
            wr_cond = COND_EXP_OPEN;
          end
        end
        MODE_CLOSE: begin
          if (cond == COND_EMPTY || cond >= COND_FULL) begin
            res.status = 1'b1;
          end else begin
            wr_en   = 1'b1;
            wr_cond = (off == '0) ? COND_EMPTY : COND_CLOSED;
          end
        end
        MODE_FINISH: begin
          wr_en   = 1'b1;
          wr_cond = COND_FULL;
          wr_off  = ZLEN;
        end
        MODE_RESET: begin
          if (cond != COND_EMPTY) begin
            wr_en   = 1'b1;
            wr_cond = COND_EMPTY;
            wr_off  = '0;
          end
        end
        MODE_RESET_ALL: begin
          // table already swept clean; only the reply remains
          res.last = 1'b1;
        end
        MODE_REPORT: begin
          if (rpt_n != 6'd0) begin
            res.zone_start         = qs[20:0];
            res.zone_write_pointer = qwp[21:0];
            res.zone_condition     = cond;
            res.reported_count     = rpt_n;
            res.last               = (rpt_i == rpt_n - 6'd1);
          end
        end
        default: begin
          res.status = 1'b1;
        end
      endcase
    end
  end

endmodule

// ===== rtl/zoned_device_zone_manager.sv =====
// Zone manager top level: command sequencer around the zone table memory.
// Depends on zdzm_pkg, zdzm_stream_if, zdzm_zone_update and zdzm_out_reg.
//
//   channel | dir | payload          | purpose
//   --------+-----+------------------+---------------------------------------
//   cmd     | in  | zdzm_pkg::cmd_t  | one zone command per request
//   res     | out | zdzm_pkg::res_t  | results; one per command, n per report
//
// A single-zone command: the accept cycle issues the table read, and the next
// cycle checks, writes back and hands the result to the output register.
// The zone table read is registered.
// A report pushes one result per zone; reset-all sweeps the table, then replies.
// After rst a clearing pass over every zone runs with cmd.ready low.
// A stalled res holds the sequencer in its result cycle; the table is untouched.
module zoned_device_zone_manager #(
  parameter int ZONE_SECTORS_LOG2 = 16,
  parameter int ZONE_COUNT        = 32
) (
  input logic           clk,
  input logic           rst,
  zdzm_stream_if.sink   cmd,
  zdzm_stream_if.source res
);
  import zdzm_pkg::*;

  localparam int ZW   = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;
  localparam int OW   = ZONE_SECTORS_LOG2 + 1;
  localparam int CW   = $clog2(ZONE_COUNT + 1);
  localparam int CMPW = (CW > 7) ? CW : 7;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t        state;
  logic [ZW-1:0] clr_idx;
  logic          clr_reply;
  cmd_t          cmd_q;
  logic          oor_q;
  logic [ZW-1:0] rpt_zone;
  logic [5:0]    rpt_n;
  logic [5:0]    rpt_i;

  // Zone table: condition and write pointer offset per zone
  logic [OW+2:0] mem [ZONE_COUNT];
  logic [OW+2:0] rdata;
  logic          mem_we;
  logic [ZW-1:0] mem_waddr;
  logic [OW+2:0] mem_wdata;
  logic          mem_re;
  logic [ZW-1:0] mem_raddr;

  logic          accept;
  logic [20:0]   zone_in;
  logic          oor_in;
  logic [CMPW-1:0] avail;
  logic [CMPW-1:0] n_in;

  logic          upd_wr_en;
  logic [2:0]    upd_cond;
  logic [OW-1:0] upd_off;
  res_t          upd_res;

  logic          push_valid;
  logic          push_ready;
  logic          rpt_walk;
  logic          rpt_last;

  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;

  // Decode the addressed zone and clamp the report count at accept
  assign zone_in = cmd.data.sector_address >> ZONE_SECTORS_LOG2;
  assign oor_in  = 32'(zone_in) >= 32'(ZONE_COUNT);
  assign avail   = CMPW'(ZONE_COUNT) - CMPW'(zone_in);

  always_comb begin
    n_in = CMPW'(cmd.data.zone_count);
    if (n_in > avail) begin
      n_in = avail;
    end
    if (n_in > CMPW'(MAX_REPORT)) begin
      n_in = CMPW'(MAX_REPORT);
    end
    if (oor_in) begin
      n_in = '0;
    end
  end

  zdzm_zone_update #(
    .ZONE_SECTORS_LOG2 (ZONE_SECTORS_LOG2),
    .ZW                (ZW),
    .OW                (OW)
  ) u_update (
    .cmd      (cmd_q),
    .oor      (oor_q),
    .cond     (rdata[OW+2:OW]),
    .off      (rdata[OW-1:0]),
    .rpt_zone (rpt_zone),
    .rpt_n    (rpt_n),
    .rpt_i    (rpt_i),
    .wr_en    (upd_wr_en),
    .wr_cond  (upd_cond),
    .wr_off   (upd_off),
    .res      (upd_res)
  );

  // Report walk: nonempty reports stay in EXEC, a zone per cycle unless stalled
  assign rpt_walk   = (cmd_q.mode == MODE_REPORT) && !oor_q && (rpt_n != 6'd0);
  assign rpt_last   = (rpt_i == rpt_n - 6'd1);
  assign push_valid = (state == S_EXEC);

  // Table access: sweep writes in CLEAR, read-modify-write in EXEC; reads are
  // issued at accept and, during a report, for the next zone as each is pushed
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ZW'(32'(cmd_q.sector_address) >> ZONE_SECTORS_LOG2);
    mem_wdata = {upd_cond, upd_off};
    mem_re    = 1'b0;
    mem_raddr = zone_in[ZW-1:0];
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx;
      mem_wdata = {COND_EMPTY, OW'(0)};
    end else if (state == S_EXEC) begin
      mem_we = push_ready && upd_wr_en;
      if (rpt_walk && push_ready && !rpt_last) begin
        mem_re    = 1'b1;
        mem_raddr = rpt_zone + ZW'(1);
      end
    end else begin
      mem_re = accept && !oor_in;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      clr_reply <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + ZW'(1);
          if (clr_idx == ZW'(ZONE_COUNT - 1)) begin
            // reset-all still owes its reply; plain reset does not
            state     <= clr_reply ? S_EXEC : S_IDLE;
            clr_reply <= 1'b0;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (cmd.data.mode == MODE_RESET_ALL) begin
              state     <= S_CLEAR;
              clr_idx   <= '0;
              clr_reply <= 1'b1;
            end else begin
              state <= S_EXEC;
            end
          end
        end
        S_EXEC: begin
          if (push_ready) begin
            if (rpt_walk && !rpt_last) begin
              rpt_zone <= rpt_zone + ZW'(1);
              rpt_i    <= rpt_i + 6'd1;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
    // Capture the request; payload registers carry no reset
    if (accept) begin
      cmd_q    <= cmd.data;
      oor_q    <= oor_in;
      rpt_zone <= zone_in[ZW-1:0];
      rpt_n    <= 6'(n_in);
      rpt_i    <= '0;
    end
  end

  zdzm_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (upd_res),
    .push_ready (push_ready),
    .res        (res)
  );

  // No result leaves while the table is being swept
  a_no_push_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !push_valid)
    else $error("result pushed during table sweep");

  // Table writes only come from the sweep or a completed command
  a_write_source: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_CLEAR) || (state == S_EXEC && push_ready))
    else $error("table written outside sweep or command completion");

  // A request other than reset-all goes straight to its execute cycle
  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.data.mode != MODE_RESET_ALL) |=> (state == S_EXEC))
    else $error("accepted request did not reach execute");

  // The report walk index never passes the clamped count
  a_report_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && rpt_walk) |-> (rpt_i < rpt_n))
    else $error("report index beyond count");

endmodule

// ===== tb/tb_zoned_device_zone_manager.sv =====
// Self-checking testbench of the zoned device zone manager: a directed table,
// then random zone commands, checked against typed-in results or a built-in model.
// Depends on zdzm_pkg, zdzm_stream_if and zoned_device_zone_manager.
module tb_zoned_device_zone_manager;
  timeunit 1ns;
  timeprecision 1ps;

  import zdzm_pkg::*;

  localparam int unsigned ZONE_LOG2    = 16;
  localparam int unsigned ZONES        = 32;
  localparam int unsigned ZONE_LEN     = 1 << ZONE_LOG2;
  localparam int unsigned RANDOM_ITEMS = 380;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 2 * ZONES + 8;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // One row of the directed table; want is only meaningful when typed is set
  typedef struct {
    cmd_t cmd;
    bit   typed;
    res_t want;
  } stim_row_t;

  typedef struct {
    bit   typed;
    res_t want;
  } literal_t;

  logic clk;
  logic rst;

  zdzm_stream_if #(.payload_t(cmd_t)) cmd_ch ();
  zdzm_stream_if #(.payload_t(res_t)) res_ch ();

  zoned_device_zone_manager #(
    .ZONE_SECTORS_LOG2(ZONE_LOG2),
    .ZONE_COUNT       (ZONES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch)
  );

  // Zone model: condition and write pointer offset of every zone
  logic [2:0]  zone_cond [ZONES];
  logic [16:0] zone_wp   [ZONES];

  res_t     results_due [$];   // results still owed by the block, oldest first
  res_t     step_res    [$];   // results of the command just applied to the model
  literal_t literal_due [$];   // typed-in results, one entry per request offered

  int unsigned cycle_count;
  int unsigned errors;
  bit          hold_req;       // ask the result side for one long hold-off
  bit          no_idle;        // suppress idling on both sides

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Apply one command to the zone model and collect the results it causes.
  function automatic void apply_zone_cmd(input cmd_t c);
    int unsigned zone;
    int unsigned zstart;
    int unsigned wp;
    int unsigned at;
    int unsigned n;
    logic [2:0]  cond;
    res_t        r;
    step_res.delete();
    r      = '0;
    r.last = 1'b1;
    zone   = 32'(c.sector_address) >> ZONE_LOG2;
    // Reset-all wipes every zone and never fails
    if (c.mode == MODE_RESET_ALL) begin
      for (int z = 0; z < ZONES; z++) begin
        zone_cond[z] = COND_EMPTY;
        zone_wp[z]   = '0;
      end
      step_res.push_back(r);
      return;
    end
    // Zone out of range: error, state untouched (report included)
    if (zone >= ZONES) begin
      r.status = 1'b1;
      step_res.push_back(r);
      return;
    end
    zstart = zone << ZONE_LOG2;
    cond   = zone_cond[zone];
    wp     = zstart + 32'(zone_wp[zone]);
    if (c.mode == MODE_REPORT) begin
      // Clamp to the zones left on the device and to the report limit
      n = 32'(c.zone_count);
      if (n > ZONES - zone) n = ZONES - zone;
      if (n > MAX_REPORT) n = MAX_REPORT;
      if (n == 0) begin
        step_res.push_back(r);
        return;
      end
      for (int unsigned i = 0; i < n; i++) begin
        r.zone_start         = 21'((zone + i) << ZONE_LOG2);
        r.zone_write_pointer = 22'(((zone + i) << ZONE_LOG2) + 32'(zone_wp[zone + i]));
        r.zone_condition     = zone_cond[zone + i];
        r.reported_count     = 6'(n);
        r.last               = (i + 1 == n);
        step_res.push_back(r);
      end
      return;
    end
    case (c.mode) inside
      MODE_WRITE, MODE_APPEND: begin
        at = (c.mode == MODE_APPEND) ? wp : 32'(c.sector_address);
        if (at != wp || wp + 32'(c.length_sectors) > zstart + ZONE_LEN
            || cond >= COND_FULL) begin
          r.status = 1'b1;
        end else begin
          // Zero-length writes still open an empty or closed zone
          if (cond == COND_EMPTY || cond == COND_CLOSED) cond = COND_IMP_OPEN;
          wp = wp + 32'(c.length_sectors);
          if (wp == zstart + ZONE_LEN) cond = COND_FULL;
          zone_cond[zone] = cond;
          zone_wp[zone]   = 17'(wp - zstart);
          r.written_at    = 21'(at);
        end
      end
      MODE_OPEN: begin
        if (cond >= COND_FULL) r.status = 1'b1;
        else zone_cond[zone] = COND_EXP_OPEN;
      end
      MODE_CLOSE: begin
        if (cond == COND_EMPTY || cond >= COND_FULL) r.status = 1'b1;
        else zone_cond[zone] = (wp == zstart) ? COND_EMPTY : COND_CLOSED;
      end
      MODE_FINISH: begin
        zone_cond[zone] = COND_FULL;
        zone_wp[zone]   = 17'(ZONE_LEN);
      end
      MODE_RESET: begin
        if (cond != COND_EMPTY) begin
          zone_cond[zone] = COND_EMPTY;
          zone_wp[zone]   = '0;
        end
      end
      default: ;
    endcase
    step_res.push_back(r);
  endfunction

  function automatic cmd_t zcmd(input logic [2:0] mode, input int unsigned addr,
                                input int unsigned len, input int unsigned cnt);
    cmd_t c;
    c.mode           = mode;
    c.sector_address = addr[20:0];
    c.length_sectors = len[16:0];
    c.zone_count     = cnt[5:0];
    return c;
  endfunction

  // Single result of a non-report command
  function automatic res_t done(input logic status, input int unsigned at);
    res_t r;
    r            = '0;
    r.status     = status;
    r.written_at = at[20:0];
    r.last       = 1'b1;
    return r;
  endfunction

  // Single result of a one-zone report
  function automatic res_t zone_rpt(input int unsigned zs, input int unsigned wp,
                                    input logic [2:0] cond);
    res_t r;
    r                    = '0;
    r.zone_start         = zs[20:0];
    r.zone_write_pointer = wp[21:0];
    r.zone_condition     = cond;
    r.reported_count     = 6'd1;
    r.last               = 1'b1;
    return r;
  endfunction

  // Draw a random command. Most writes and appends are aimed at the write
  // pointer with a length that fits, so zones fill up, close and reopen;
  // the rest are off-pointer, overlong or plain noise.
  function automatic cmd_t random_zone_cmd();
    cmd_t        c;
    int unsigned zone;
    int unsigned room;
    int unsigned cap;
    int unsigned roll;
    int unsigned lroll;
    c.length_sectors = 17'($urandom);
    c.zone_count     = 6'($urandom);
    zone = ($urandom_range(99) < 60) ? $urandom_range(3) : $urandom_range(ZONES - 1);
    c.sector_address = 21'((zone << ZONE_LOG2) | $urandom_range(ZONE_LEN - 1));
    room = ZONE_LEN - 32'(zone_wp[zone]);
    roll = $urandom_range(99);
    if (roll < 30) c.mode = MODE_WRITE;
    else if (roll < 50) c.mode = MODE_APPEND;
    else if (roll < 57) c.mode = MODE_OPEN;
    else if (roll < 64) c.mode = MODE_CLOSE;
    else if (roll < 69) c.mode = MODE_FINISH;
    else if (roll < 78) c.mode = MODE_RESET;
    else if (roll < 81) c.mode = MODE_RESET_ALL;
    else c.mode = MODE_REPORT;
    if (c.mode == MODE_WRITE || c.mode == MODE_APPEND) begin
      if (room != 0 && $urandom_range(99) < 80) begin
        c.sector_address = 21'((zone << ZONE_LOG2) + 32'(zone_wp[zone]));
      end
      cap   = (room < 2048) ? room : 2048;
      lroll = $urandom_range(99);
      if (lroll < 65) c.length_sectors = 17'($urandom_range(cap, 0));
      else if (lroll < 78) c.length_sectors = 17'(room);
      else if (lroll < 88) c.length_sectors = 17'(room + $urandom_range(8, 1));
    end else if (c.mode == MODE_REPORT && $urandom_range(99) < 75) begin
      c.zone_count = 6'($urandom_range(8, 1));
    end
    return c;
  endfunction

  // Offer one request; return at the falling edge after it is accepted.
  task automatic send_zone_cmd(input cmd_t c, input bit typed, input res_t want);
    literal_t lit;
    lit.typed = typed;
    lit.want  = want;
    literal_due.push_back(lit);
    while (!no_idle && $urandom_range(99) < 6) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= c;
    do @(posedge clk); while (!cmd_ch.ready);
    @(negedge clk);
  endtask

  task automatic flag_field(input string name, input logic [21:0] want,
                            input logic [21:0] got);
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    errors++;
  endtask

  // Result side: mostly ready, one long hold-off on request so the block
  // backs up and stalls its request input.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      res_ch.ready <= no_idle || ($urandom_range(99) >= 6);
    end
  end

  // Predict on every accepted request, check every accepted result.
  always @(posedge clk) begin
    literal_t lit;
    res_t     want;
    res_t     got;
    if (!rst && cmd_ch.valid && cmd_ch.ready) begin
      lit = literal_due.pop_front();
      apply_zone_cmd(cmd_ch.data);
      // A typed-in row replaces the model's answer; the model state still advances
      if (lit.typed) results_due.push_back(lit.want);
      else foreach (step_res[k]) results_due.push_back(step_res[k]);
    end
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = res_ch.data;
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = results_due.pop_front();
        if (got.status !== want.status)
          flag_field("status", 22'(want.status), 22'(got.status));
        if (got.written_at !== want.written_at)
          flag_field("written_at", 22'(want.written_at), 22'(got.written_at));
        if (got.zone_start !== want.zone_start)
          flag_field("zone_start", 22'(want.zone_start), 22'(got.zone_start));
        if (got.zone_write_pointer !== want.zone_write_pointer)
          flag_field("zone_write_pointer", want.zone_write_pointer, got.zone_write_pointer);
        if (got.zone_condition !== want.zone_condition)
          flag_field("zone_condition", 22'(want.zone_condition), 22'(got.zone_condition));
        if (got.reported_count !== want.reported_count)
          flag_field("reported_count", 22'(want.reported_count), 22'(got.reported_count));
        if (got.last !== want.last)
          flag_field("last", 22'(want.last), 22'(got.last));
      end
    end
  end

  // Watchdog: allows for the clearing pass, the hold-off and full-size reports
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    stim_row_t directed [$];
    cmd_t      c;
    rst          = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.data  = '0;
    hold_req     = 1'b0;
    no_idle      = 1'b0;
    errors       = 0;
    cycle_count  = 0;
    for (int z = 0; z < ZONES; z++) begin
      zone_cond[z] = COND_EMPTY;
      zone_wp[z]   = '0;
    end

    // Zone 1 starts at 65536, zone 2 at 131072, zone 5 at 327680,
    // zone 7 at 458752, zone 31 at 2031616.
    directed = '{
      // fresh device: zone 0 empty, pointer at start
      '{zcmd(MODE_REPORT, 0, 0, 1), 1'b1, zone_rpt(0, 0, COND_EMPTY)},
      // report from the last zone clamps to one zone
      '{zcmd(MODE_REPORT, 2031616, 0, 5), 1'b1, zone_rpt(2031616, 2031616, COND_EMPTY)},
      // empty report
      '{zcmd(MODE_REPORT, 196608, 0, 0), 1'b1, done(1'b0, 0)},
      // zero-length write opens zone 0 implicitly
      '{zcmd(MODE_WRITE, 0, 0, 0), 1'b1, done(1'b0, 0)},
      // write off the pointer
      '{zcmd(MODE_WRITE, 5, 1, 0), 1'b1, done(1'b1, 0)},
      '{zcmd(MODE_APPEND, 0, 100, 0), 1'b1, done(1'b0, 0)},
      // one sector past capacity
      '{zcmd(MODE_WRITE, 100, 65437, 0), 1'b1, done(1'b1, 0)},
      // exact fill marks zone 0 full
      '{zcmd(MODE_WRITE, 100, 65436, 0), 1'b1, done(1'b0, 100)},
      // append, open and close of a full zone all fail
      '{zcmd(MODE_APPEND, 0, 0, 0), 1'b1, done(1'b1, 0)},
      '{zcmd(MODE_OPEN, 0, 0, 0), 1'b1, done(1'b1, 0)},
      '{zcmd(MODE_CLOSE, 0, 0, 0), 1'b1, done(1'b1, 0)},
      // close of an empty zone fails
      '{zcmd(MODE_CLOSE, 65536, 0, 0), 1'b1, done(1'b1, 0)},
      // explicit open, then close back to empty at the zone start
      '{zcmd(MODE_OPEN, 65536, 0, 0), 1'b0, '0},
      '{zcmd(MODE_CLOSE, 65536, 0, 0), 1'b0, '0},
      // full-zone append from an empty zone; low address bits are ignored
      '{zcmd(MODE_APPEND, 131072 + 12345, 65536, 0), 1'b1, done(1'b0, 131072)},
      '{zcmd(MODE_WRITE, 2031616, 1, 0), 1'b1, done(1'b0, 2031616)},
      // close with data gives closed, open of closed gives explicitly open
      '{zcmd(MODE_CLOSE, 2031616, 0, 0), 1'b0, '0},
      '{zcmd(MODE_OPEN, 2031616, 0, 0), 1'b0, '0},
      // all-ones length runs past capacity
      '{zcmd(MODE_APPEND, 2031616, 131071, 63), 1'b1, done(1'b1, 0)},
      '{zcmd(MODE_FINISH, 327680, 0, 0), 1'b0, '0},
      // reset of an empty zone changes nothing
      '{zcmd(MODE_RESET, 65536, 0, 0), 1'b0, '0},
      '{zcmd(MODE_RESET, 327680, 0, 0), 1'b0, '0},
      '{zcmd(MODE_WRITE, 458752 + 65535, 1, 0), 1'b1, done(1'b1, 0)},
      // every zone, count clamped to the device
      '{zcmd(MODE_REPORT, 0, 0, 63), 1'b0, '0},
      '{zcmd(MODE_RESET_ALL, 2097151, 131071, 63), 1'b1, done(1'b0, 0)},
      '{zcmd(MODE_REPORT, 0, 0, 32), 1'b0, '0}
    };

    // Hold reset, then release at a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[i]) send_zone_cmd(directed[i].cmd, directed[i].typed, directed[i].want);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 60) hold_req = 1'b1;
      if (n == 180) begin
        // Pause the request side until every result has come back
        cmd_ch.valid <= 1'b0;
        do @(negedge clk); while (results_due.size() != 0);
      end
      no_idle = (n >= 250 && n < 330);
      c = random_zone_cmd();
      send_zone_cmd(c, 1'b0, '0);
    end
    no_idle = 1'b0;

    // Drain, then allow for a trailing report or reset-all walk
    cmd_ch.valid <= 1'b0;
    do @(negedge clk); while (results_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
